// ----- hw/rtl/world_to_grid_cell_quantizer_defines.svh -----
// Assertion macros for the grid cell quantizer.
// Standalone header; included by the top level only.
`ifndef WORLD_TO_GRID_CELL_QUANTIZER_DEFINES_SVH
`define WORLD_TO_GRID_CELL_QUANTIZER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WGQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("quantizer assertion failed");
// next-cycle implication
`define WGQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("quantizer assertion failed");
`else
`define WGQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WGQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/wgq_pkg.sv -----
// Shared types and constants of the grid cell quantizer.
// No dependencies.
package wgq_pkg;

    localparam int COORD_W        = 64;
    localparam int CELL_W         = 32;
    localparam int LOD_W          = 5;
    localparam int LAYER_W        = 16;
    localparam int LAYER_BITS     = 16;
    localparam int LODCNT_W       = 6;
    localparam int MAX_LOD_LEVELS = 32;
    localparam int SIZE_W         = 63;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_AXES       = 3;
    localparam int Q_W            = COORD_W + 1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_POLICY   = 3'd1,
        ST_LAYER    = 3'd2,
        ST_LOD      = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_BOUNDS   = 3'd5
    } wgq_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_BASE_SIZE  = 3'd3,
        REG_BOUNDS_X   = 3'd4,
        REG_BOUNDS_Y   = 3'd5,
        REG_BOUNDS_Z   = 3'd6,
        REG_LOD_LEVELS = 3'd7
    } wgq_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0]                    base;
        logic [NUM_AXES-1:0][COORD_W-1:0]     origin;
        logic [NUM_AXES-1:0][2*CELL_W-1:0]    bounds;
        logic [LODCNT_W-1:0]                  lod_levels;
    } wgq_cfg_t;

    typedef struct packed {
        wgq_status_t          status;
        logic [LOD_W-1:0]     lod;
        logic [LAYER_W-1:0]   layer;
        logic [NUM_AXES-1:0]  neg;
    } wgq_side_t;

    typedef struct packed {
        logic                              valid;
        wgq_side_t                         side;
        logic [SIZE_W-1:0]                 divisor;
        logic [NUM_AXES-1:0][SIZE_W-1:0]   rem;
        logic [NUM_AXES-1:0][COORD_W-1:0]  num;
    } wgq_div_t;

endpackage

// ----- hw/rtl/wgq_front.sv -----
// Front end: policy/layer/lod checks, origin subtract, magnitude and divisor.
// Depends on wgq_pkg.
module wgq_front (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              en,
    input  logic                                              in_valid,
    input  logic [wgq_pkg::NUM_AXES-1:0][wgq_pkg::COORD_W-1:0] coord,
    input  logic [wgq_pkg::LOD_W-1:0]                          lod,
    input  logic [wgq_pkg::LAYER_W-1:0]                        layer,
    input  wgq_pkg::wgq_cfg_t                                  cfg,
    output wgq_pkg::wgq_div_t                                  out
);

    // stage A: checks and subtract
    logic                                               a_valid_reg;
    wgq_pkg::wgq_status_t                               a_status_reg, a_status_next;
    logic [wgq_pkg::NUM_AXES-1:0][wgq_pkg::COORD_W-1:0] a_diff_reg, a_diff_next;
    logic [wgq_pkg::SIZE_W-1:0]                         a_div_reg, a_div_next;
    logic [wgq_pkg::LOD_W-1:0]                          a_lod_reg;
    logic [wgq_pkg::LAYER_W-1:0]                        a_layer_reg;

    // stage B: magnitude
    logic                  b_valid_reg;
    wgq_pkg::wgq_div_t     b_data_reg, b_data_next;

    logic                            pol_bad;
    logic [wgq_pkg::NUM_AXES-1:0]    ovf;
    logic [wgq_pkg::SIZE_W-1:0]      size_lim;

    always_comb begin
        size_lim = {wgq_pkg::SIZE_W{1'b1}} >> (cfg.lod_levels - 6'd1);
        pol_bad  = (cfg.base == '0) || (cfg.lod_levels == '0)
                || (cfg.lod_levels > wgq_pkg::LODCNT_W'(wgq_pkg::MAX_LOD_LEVELS))
                || (cfg.base > size_lim);
        for (int a = 0; a < wgq_pkg::NUM_AXES; a++) begin
            if ($signed(cfg.bounds[a][31:0]) > $signed(cfg.bounds[a][63:32])) begin
                pol_bad = 1'b1;
            end
            a_diff_next[a] = coord[a] - cfg.origin[a];
            ovf[a] = (coord[a][63] ^ cfg.origin[a][63]) & (coord[a][63] ^ a_diff_next[a][63]);
        end
        a_div_next = wgq_pkg::SIZE_W'(cfg.base << lod);
        if (pol_bad) begin
            a_status_next = wgq_pkg::ST_POLICY;
        end else if (layer[wgq_pkg::LAYER_BITS-1:0] == '0) begin
            a_status_next = wgq_pkg::ST_LAYER;
        end else if ({1'b0, lod} >= cfg.lod_levels) begin
            a_status_next = wgq_pkg::ST_LOD;
        end else if (|ovf) begin
            a_status_next = wgq_pkg::ST_OVERFLOW;
        end else begin
            a_status_next = wgq_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_status_reg <= a_status_next;
            a_diff_reg   <= a_diff_next;
            a_div_reg    <= a_div_next;
            a_lod_reg    <= lod;
            a_layer_reg  <= layer;
        end
    end

    always_comb begin
        b_data_next             = '0;
        b_data_next.side.status = a_status_reg;
        b_data_next.side.lod    = a_lod_reg;
        b_data_next.side.layer  = a_layer_reg;
        b_data_next.divisor     = a_div_reg;
        for (int a = 0; a < wgq_pkg::NUM_AXES; a++) begin
            b_data_next.side.neg[a] = a_diff_reg[a][63];
            b_data_next.num[a] = a_diff_reg[a][63] ? (~a_diff_reg[a] + 64'd1) : a_diff_reg[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_data_reg <= b_data_next;
        end
    end

    always_comb begin
        out       = b_data_reg;
        out.valid = b_valid_reg;
    end

endmodule

// ----- hw/rtl/wgq_div_step.sv -----
// One restoring divide step for all three axes, registered.
// Depends on wgq_pkg.
module wgq_div_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  wgq_pkg::wgq_div_t  in,
    output wgq_pkg::wgq_div_t  out
);

    logic              valid_reg;
    wgq_pkg::wgq_div_t data_reg, data_next;
    logic [wgq_pkg::COORD_W-1:0] trial, sub;
    logic                        ge;

    always_comb begin
        data_next = in;
        trial     = '0;
        sub       = '0;
        ge        = 1'b0;
        for (int a = 0; a < wgq_pkg::NUM_AXES; a++) begin
            trial = {in.rem[a], in.num[a][wgq_pkg::COORD_W-1]};
            sub   = trial - {1'b0, in.divisor};
            ge    = trial >= {1'b0, in.divisor};
            data_next.rem[a] = ge ? sub[wgq_pkg::SIZE_W-1:0] : trial[wgq_pkg::SIZE_W-1:0];
            data_next.num[a] = {in.num[a][wgq_pkg::COORD_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        out       = data_reg;
        out.valid = valid_reg;
    end

endmodule

// ----- hw/rtl/wgq_div.sv -----
// Pipelined unsigned divider, one quotient bit per stage.
// Depends on wgq_pkg and wgq_div_step.
module wgq_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  wgq_pkg::wgq_div_t  in,
    output wgq_pkg::wgq_div_t  out
);

    wgq_pkg::wgq_div_t stage [0:wgq_pkg::COORD_W];

    assign stage[0] = in;

    for (genvar i = 0; i < wgq_pkg::COORD_W; i++) begin : g_step
        wgq_div_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in      (stage[i]),
            .out     (stage[i+1])
        );
    end

    assign out = stage[wgq_pkg::COORD_W];

endmodule

// ----- hw/rtl/wgq_back.sv -----
// Back end: floor correction, bounds check, output register.
// Depends on wgq_pkg.
module wgq_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  wgq_pkg::wgq_div_t                    in,
    input  wgq_pkg::wgq_cfg_t                    cfg,
    output logic                                 out_valid,
    output logic [2:0]                           out_status,
    output logic [wgq_pkg::NUM_AXES-1:0][wgq_pkg::CELL_W-1:0] out_cell,
    output logic [wgq_pkg::LOD_W-1:0]            out_lod,
    output logic [wgq_pkg::LAYER_W-1:0]          out_layer
);

    // stage C: signed floor quotient
    logic                  c_valid_reg;
    wgq_pkg::wgq_side_t    c_side_reg;
    logic signed [wgq_pkg::Q_W-1:0] c_q_reg  [wgq_pkg::NUM_AXES];
    logic signed [wgq_pkg::Q_W-1:0] c_q_next [wgq_pkg::NUM_AXES];

    // stage D: output
    logic                  d_valid_reg;
    wgq_pkg::wgq_status_t  d_status_reg, d_status_next;
    logic [wgq_pkg::NUM_AXES-1:0][wgq_pkg::CELL_W-1:0] d_cell_reg, d_cell_next;
    logic [wgq_pkg::LOD_W-1:0]   d_lod_reg;
    logic [wgq_pkg::LAYER_W-1:0] d_layer_reg;

    logic oob;

    always_comb begin
        for (int a = 0; a < wgq_pkg::NUM_AXES; a++) begin
            // negative side rounds down when a remainder is left
            if (in.side.neg[a]) begin
                c_q_next[a] = -$signed({1'b0, in.num[a]})
                              - $signed({{(wgq_pkg::Q_W-1){1'b0}}, (in.rem[a] != '0)});
            end else begin
                c_q_next[a] = $signed({1'b0, in.num[a]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= in.side;
            for (int a = 0; a < wgq_pkg::NUM_AXES; a++) begin
                c_q_reg[a] <= c_q_next[a];
            end
        end
    end

    always_comb begin
        oob = 1'b0;
        for (int a = 0; a < wgq_pkg::NUM_AXES; a++) begin
            if (c_q_reg[a] < $signed(cfg.bounds[a][31:0])
                || c_q_reg[a] > $signed(cfg.bounds[a][63:32])) begin
                oob = 1'b1;
            end
        end
        d_status_next = c_side_reg.status;
        if (c_side_reg.status == wgq_pkg::ST_OK && oob) begin
            d_status_next = wgq_pkg::ST_BOUNDS;
        end
        for (int a = 0; a < wgq_pkg::NUM_AXES; a++) begin
            d_cell_next[a] = (d_status_next == wgq_pkg::ST_OK)
                           ? c_q_reg[a][wgq_pkg::CELL_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_status_reg <= d_status_next;
            d_cell_reg   <= d_cell_next;
            d_lod_reg    <= c_side_reg.lod;
            d_layer_reg  <= c_side_reg.layer;
        end
    end

    assign out_valid  = d_valid_reg;
    assign out_status = d_status_reg;
    assign out_cell   = d_cell_reg;
    assign out_lod    = d_lod_reg;
    assign out_layer  = d_layer_reg;

endmodule

// ----- hw/rtl/world_to_grid_cell_quantizer.sv -----
// Top level of the world-to-grid-cell quantizer.
// Depends on wgq_pkg, wgq_front, wgq_div, wgq_back and the defines header.

// World-to-grid-cell quantizer. Each s_ transfer carries a 64-bit signed
// position (mm), a detail level and a layer id; each m_ transfer returns one
// result: status, cell index per axis (zero unless status is ok), and the
// echoed lod and layer. The block is a 68-stage pipeline: 2 front stages
// (checks, origin subtract with overflow detect, magnitude and divisor
// base_cell_size << lod), 64 restoring divide stages (one quotient bit per
// stage, all three axes side by side), and 2 back stages (floor correction,
// bounds check into the output register). One item per cycle is accepted
// sustained while m_ready holds. A stall on the m_ side freezes the whole
// pipeline, so s_ready = m_ready | ~m_valid.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register
// per cycle; write it only while the pipeline is empty.
`include "world_to_grid_cell_quantizer_defines.svh"

module world_to_grid_cell_quantizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [wgq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wgq_pkg::COORD_W-1:0]       cfg_wdata,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [wgq_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [wgq_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [wgq_pkg::COORD_W-1:0] s_coord_z,
    input  logic [wgq_pkg::LOD_W-1:0]         s_detail_level,
    input  logic [wgq_pkg::LAYER_W-1:0]       s_layer_id,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic signed [wgq_pkg::CELL_W-1:0] m_cell_x,
    output logic signed [wgq_pkg::CELL_W-1:0] m_cell_y,
    output logic signed [wgq_pkg::CELL_W-1:0] m_cell_z,
    output logic [wgq_pkg::LOD_W-1:0]         m_cell_lod,
    output logic [wgq_pkg::LAYER_W-1:0]       m_cell_layer
);

    wgq_pkg::wgq_cfg_t cfg_reg;
    logic              en;
    wgq_pkg::wgq_div_t front_out, div_out;
    logic [wgq_pkg::NUM_AXES-1:0][wgq_pkg::COORD_W-1:0] coord;
    logic [wgq_pkg::NUM_AXES-1:0][wgq_pkg::CELL_W-1:0]  cell_idx;

    // whole pipeline advances unless the output holds an untaken result
    assign en      = m_ready | ~m_valid;
    assign s_ready = en;

    // register writes; values masked to register widths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin     <= '0;
            cfg_reg.bounds     <= '0;
            cfg_reg.base       <= wgq_pkg::SIZE_W'(1);
            cfg_reg.lod_levels <= wgq_pkg::LODCNT_W'(1);
        end else if (cfg_we) begin
            case (wgq_pkg::wgq_reg_t'(cfg_index))
                wgq_pkg::REG_ORIGIN_X:   cfg_reg.origin[0] <= cfg_wdata;
                wgq_pkg::REG_ORIGIN_Y:   cfg_reg.origin[1] <= cfg_wdata;
                wgq_pkg::REG_ORIGIN_Z:   cfg_reg.origin[2] <= cfg_wdata;
                wgq_pkg::REG_BASE_SIZE:  cfg_reg.base <= cfg_wdata[wgq_pkg::SIZE_W-1:0];
                wgq_pkg::REG_BOUNDS_X:   cfg_reg.bounds[0] <= cfg_wdata;
                wgq_pkg::REG_BOUNDS_Y:   cfg_reg.bounds[1] <= cfg_wdata;
                wgq_pkg::REG_BOUNDS_Z:   cfg_reg.bounds[2] <= cfg_wdata;
                wgq_pkg::REG_LOD_LEVELS: begin
                    cfg_reg.lod_levels <= cfg_wdata[wgq_pkg::LODCNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign coord[0] = s_coord_x;
    assign coord[1] = s_coord_y;
    assign coord[2] = s_coord_z;

    wgq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .coord    (coord),
        .lod      (s_detail_level),
        .layer    (s_layer_id),
        .cfg      (cfg_reg),
        .out      (front_out)
    );

    wgq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in      (front_out),
        .out     (div_out)
    );

    wgq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in         (div_out),
        .cfg        (cfg_reg),
        .out_valid  (m_valid),
        .out_status (m_status),
        .out_cell   (cell_idx),
        .out_lod    (m_cell_lod),
        .out_layer  (m_cell_layer)
    );

    assign m_cell_x = cell_idx[0];
    assign m_cell_y = cell_idx[1];
    assign m_cell_z = cell_idx[2];

    // any failing status zeroes every index
    `WGQ_ASSERT_IMP(a_fail_zero, aclk, aresetn, m_valid && m_status != wgq_pkg::ST_OK, m_cell_x == '0 && m_cell_y == '0 && m_cell_z == '0)
    // an ok result lies inside the x bounds
    `WGQ_ASSERT_IMP(a_ok_in_x, aclk, aresetn, m_valid && m_status == wgq_pkg::ST_OK, $signed(m_cell_x) >= $signed(cfg_reg.bounds[0][31:0]) && $signed(m_cell_x) <= $signed(cfg_reg.bounds[0][63:32]))
    // a stall only comes from a held result
    `WGQ_ASSERT_IMP(a_stall_src, aclk, aresetn, !s_ready, m_valid && !m_ready)
    // a held result keeps its status through the stall
    `WGQ_ASSERT_NXT(a_hold_status, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status))

endmodule
